### hdl/hcfr_pkg.sv
`timescale 1ns / 1ps
package hcfr_pkg;

   // result kinds on the rsp channel
   localparam logic [1:0] KIND_TX      = 2'd0;
   localparam logic [1:0] KIND_LED     = 2'd1;
   localparam logic [1:0] KIND_CHK_ERR = 2'd2;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   // reply classes handed from parser to emitter
   localparam logic [1:0] REPLY_UNKNOWN = 2'd0;
   localparam logic [1:0] REPLY_CHK_ERR = 2'd1;
   localparam logic [1:0] REPLY_LED     = 2'd2;
   localparam logic [1:0] REPLY_QUERY   = 2'd3;

   localparam logic [7:0] FRAME_QUERY = 8'h00;
   localparam logic [7:0] FRAME_LED   = 8'h01;

   localparam int unsigned DATA_BYTES = 5;

   typedef struct packed {
      logic [1:0]                  reply;
      logic [7:0]                  seq;
      logic [DATA_BYTES-1:0][7:0]  data;
      logic [7:0]                  check;
   } reply_type;

endpackage

### hdl/host_command_frame_responder_core.sv
`timescale 1ns / 1ps
// host command frame responder
// req channel: one host link byte per item, together with the current colour
// and reflector sensor readings (sampled only when a query frame completes).
// rsp channel: result items; kind 0 is a byte to send back to the host,
// kind 1 an LED setting, kind 2 a check byte error, kind 3 an unknown type.
// rsp_last marks the final result caused by one input byte.
// a valid type byte, sequence and payload bytes give no result. a completed
// query frame gives 8 results, an LED frame 4, an error 1.
// the edge that takes a byte loads its reply into the parser reply register;
// the reply moves into the emitter register once the emitter takes it, and
// its first result is on rsp from then on.
// throughput: one byte per cycle while req_ready is high; the emitter sends
// one result per cycle while rsp_ready is high, 1, 4 or 8 per reply, and
// req_ready drops only if the next reply completes before the current is done.
// reset (synchronous, active high) returns the parser to waiting for a type
// byte and drops any pending reply.
// a stall on rsp_ready holds the current result; the parser keeps taking
// bytes until the reply register between parser and emitter is occupied.
module host_command_frame_responder_core
   import hcfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_color_red,
   input  logic [7:0]  req_color_green,
   input  logic [7:0]  req_color_blue,
   input  logic [9:0]  req_reflect_a,
   input  logic [9:0]  req_reflect_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic [7:0]  rsp_led_red,
   output logic [7:0]  rsp_led_green,
   output logic [7:0]  rsp_led_blue,
   output logic [7:0]  rsp_led_brightness,
   output logic        rsp_last
);

   logic      take;
   logic      pend_valid;
   reply_type pend_reply;

   hcfr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .rx_byte     (req_rx_byte),
      .color_red   (req_color_red),
      .color_green (req_color_green),
      .color_blue  (req_color_blue),
      .reflect_a   (req_reflect_a),
      .reflect_b   (req_reflect_b),
      .take        (take),
      .pend_valid  (pend_valid),
      .pend_reply  (pend_reply)
   );

   hcfr_emitter u_emitter (
      .clock              (clock),
      .reset              (reset),
      .pend_valid         (pend_valid),
      .pend_reply         (pend_reply),
      .take               (take),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_led_red        (rsp_led_red),
      .rsp_led_green      (rsp_led_green),
      .rsp_led_blue       (rsp_led_blue),
      .rsp_led_brightness (rsp_led_brightness),
      .rsp_last           (rsp_last)
   );

   // error results stand alone
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_CHK_ERR || rsp_kind == KIND_UNKNOWN) |-> rsp_last)
      else $error("error result not marked last");

   // LED setting always opens a reply, never ends it
   a_led_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_LED |-> !rsp_last)
      else $error("LED result marked last");

   // after an LED setting is taken, the echoed type byte follows
   a_led_then_type: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_kind == KIND_LED |=>
         rsp_valid && rsp_kind == KIND_TX && rsp_tx_byte == FRAME_LED)
      else $error("LED reply not followed by type byte");

   // the parser only backs off while a reply waits for the emitter
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> pend_valid && rsp_valid)
      else $error("req_ready low with no pending reply");

endmodule

### hdl/hcfr_parser.sv
`timescale 1ns / 1ps
module hcfr_parser
   import hcfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  rx_byte,
   input  logic [7:0]  color_red,
   input  logic [7:0]  color_green,
   input  logic [7:0]  color_blue,
   input  logic [9:0]  reflect_a,
   input  logic [9:0]  reflect_b,
   input  logic        take,
   output logic        pend_valid,
   output reply_type   pend_reply
);

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_SEQ    = 3'd1;
   localparam logic [2:0] PH_PAY0   = 3'd2;
   localparam logic [2:0] PH_PAY1   = 3'd3;
   localparam logic [2:0] PH_PAY2   = 3'd4;
   localparam logic [2:0] PH_PAY3   = 3'd5;
   localparam logic [2:0] PH_CHECK  = 3'd6;
   localparam logic [2:0] PH_UNUSED = 3'd7;

   logic [2:0]      phase_ff, phase_in;
   logic            is_led_ff, is_led_in;
   logic [7:0]      seq_ff, seq_in;
   logic [7:0]      check_ff, check_in;
   logic [3:0][7:0] payload_ff;
   logic            pend_valid_ff, pend_valid_in;
   reply_type       pend_reply_ff, pend_reply_in;

   logic            accept;
   logic            emit;
   logic            pay_wr;
   logic [2:0]      pay_off;
   logic [1:0]      pay_idx;
   logic [7:0]      ref_a_hi;
   logic [7:0]      ref_b_hi;

   assign req_ready  = !pend_valid_ff || take;
   assign accept     = req_valid && req_ready;
   assign pay_off    = phase_ff - PH_PAY0;
   assign pay_idx    = pay_off[1:0];
   assign ref_a_hi   = reflect_a[9:2];
   assign ref_b_hi   = reflect_b[9:2];
   assign pend_valid = pend_valid_ff;
   assign pend_reply = pend_reply_ff;

   always_comb begin
      phase_in      = phase_ff;
      is_led_in     = is_led_ff;
      seq_in        = seq_ff;
      check_in      = check_ff;
      emit          = 1'b0;
      pay_wr        = 1'b0;
      pend_reply_in = pend_reply_ff;
      if (accept) begin
         unique case (phase_ff) inside
            PH_IDLE, PH_UNUSED: begin
               if (rx_byte == FRAME_QUERY || rx_byte == FRAME_LED) begin
                  is_led_in = rx_byte[0];
                  check_in  = rx_byte;
                  phase_in  = PH_SEQ;
               end else begin
                  phase_in            = PH_IDLE;
                  emit                = 1'b1;
                  pend_reply_in       = '0;
                  pend_reply_in.reply = REPLY_UNKNOWN;
               end
            end
            PH_SEQ: begin
               seq_in   = rx_byte;
               check_in = check_ff ^ rx_byte;
               phase_in = is_led_ff ? PH_PAY0 : PH_CHECK;
            end
            PH_PAY0, PH_PAY1, PH_PAY2, PH_PAY3: begin
               pay_wr   = 1'b1;
               check_in = check_ff ^ rx_byte;
               phase_in = phase_ff + 3'd1;
            end
            PH_CHECK: begin
               phase_in      = PH_IDLE;
               emit          = 1'b1;
               pend_reply_in = '0;
               if (rx_byte != check_ff) begin
                  pend_reply_in.reply = REPLY_CHK_ERR;
               end else if (is_led_ff) begin
                  pend_reply_in.reply     = REPLY_LED;
                  pend_reply_in.seq       = seq_ff;
                  pend_reply_in.data[3:0] = payload_ff;
               end else begin
                  pend_reply_in.reply   = REPLY_QUERY;
                  pend_reply_in.seq     = seq_ff;
                  pend_reply_in.data[0] = color_red;
                  pend_reply_in.data[1] = color_green;
                  pend_reply_in.data[2] = color_blue;
                  pend_reply_in.data[3] = ref_a_hi;
                  pend_reply_in.data[4] = ref_b_hi;
                  pend_reply_in.check   = FRAME_QUERY ^ seq_ff ^ color_red ^ color_green
                                          ^ color_blue ^ ref_a_hi ^ ref_b_hi;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
      if (emit) begin
         pend_valid_in = 1'b1;
      end else if (take) begin
         pend_valid_in = 1'b0;
      end else begin
         pend_valid_in = pend_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         is_led_ff     <= 1'b0;
         seq_ff        <= '0;
         check_ff      <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         is_led_ff     <= is_led_in;
         seq_ff        <= seq_in;
         check_ff      <= check_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_reply_ff <= pend_reply_in;
      if (pay_wr) begin
         payload_ff[pay_idx] <= rx_byte;
      end
   end

endmodule

### hdl/hcfr_emitter.sv
`timescale 1ns / 1ps
module hcfr_emitter
   import hcfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        pend_valid,
   input  reply_type   pend_reply,
   output logic        take,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic [7:0]  rsp_led_red,
   output logic [7:0]  rsp_led_green,
   output logic [7:0]  rsp_led_blue,
   output logic [7:0]  rsp_led_brightness,
   output logic        rsp_last
);

   logic       busy_ff, busy_in;
   reply_type  cur_ff, cur_in;
   logic [2:0] idx_ff, idx_in;
   logic       fire;

   assign rsp_valid = busy_ff;
   assign fire      = busy_ff && rsp_ready;
   assign take      = !busy_ff || (rsp_ready && rsp_last);

   always_comb begin
      busy_in = busy_ff;
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      if (take) begin
         busy_in = pend_valid;
         cur_in  = pend_reply;
         idx_in  = '0;
      end else if (fire) begin
         idx_in  = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // result fields for the current position in the reply
   always_comb begin
      rsp_kind           = KIND_TX;
      rsp_tx_byte        = '0;
      rsp_led_red        = '0;
      rsp_led_green      = '0;
      rsp_led_blue       = '0;
      rsp_led_brightness = '0;
      rsp_last           = 1'b0;
      unique case (cur_ff.reply)
         REPLY_UNKNOWN: begin
            rsp_kind = KIND_UNKNOWN;
            rsp_last = 1'b1;
         end
         REPLY_CHK_ERR: begin
            rsp_kind = KIND_CHK_ERR;
            rsp_last = 1'b1;
         end
         REPLY_LED: begin
            case (idx_ff)
               3'd0: begin
                  rsp_kind           = KIND_LED;
                  rsp_led_red        = cur_ff.data[0];
                  rsp_led_green      = cur_ff.data[1];
                  rsp_led_blue       = cur_ff.data[2];
                  rsp_led_brightness = cur_ff.data[3];
               end
               3'd1:    rsp_tx_byte = FRAME_LED;
               3'd2:    rsp_tx_byte = cur_ff.seq;
               default: begin
                  rsp_tx_byte = FRAME_LED ^ cur_ff.seq;
                  rsp_last    = 1'b1;
               end
            endcase
         end
         REPLY_QUERY: begin
            case (idx_ff)
               3'd0:    rsp_tx_byte = FRAME_QUERY;
               3'd1:    rsp_tx_byte = cur_ff.seq;
               3'd2:    rsp_tx_byte = cur_ff.data[0];
               3'd3:    rsp_tx_byte = cur_ff.data[1];
               3'd4:    rsp_tx_byte = cur_ff.data[2];
               3'd5:    rsp_tx_byte = cur_ff.data[3];
               3'd6:    rsp_tx_byte = cur_ff.data[4];
               default: begin
                  rsp_tx_byte = cur_ff.check;
                  rsp_last    = 1'b1;
               end
            endcase
         end
         default: begin
            rsp_last = 1'b1;
         end
      endcase
   end

endmodule
